// ===== design/spli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spli_pkg
// Shared widths, register indexes and interface types of the lerp indexer.
// ----------------------------------------------------------------------------
package spli_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int IDX_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = IDX_W + FRAC_W;
    localparam int INC_W      = 8 + FRAC_W;
    localparam int CNT_W      = 7;
    localparam int K_W        = 6;
    localparam int MF_W       = IDX_W + 1;
    localparam int WA_W       = FRAC_W + 1;
    localparam int RELA_W     = 14;
    localparam int RELB_W     = 15;
    // The accumulator has headroom for 64 steps of an inverted loop wrap.
    localparam int ACC_W      = POS_W + 8;
    localparam int REL_W      = FRAC_W + 15;
    localparam int DELTA_W    = IDX_W + 2;

    localparam int S_DATA_W   = 104;
    localparam int M_DATA_W   = 152;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PRESENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LAST     = 3'd4;

    typedef struct packed {
        logic capture;
        logic setup;
        logic wrap_prep;
        logic advance;
        logic last;
    } ctrl_t;

    typedef struct packed {
        logic [POS_W-1:0]  next_position;
        logic [RELB_W-1:0] relative_b;
        logic [RELA_W-1:0] relative_a;
        logic [FRAC_W-1:0] weight_b;
        logic [WA_W-1:0]   weight_a;
        logic [IDX_W-1:0]  index_b;
        logic [IDX_W-1:0]  index_a;
    } rec_t;

endpackage

// ===== design/spli_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spli_seq
// Sequencer: takes a request, runs two setup steps, then steps the shared
// position accumulator once per output record.
// ----------------------------------------------------------------------------
module spli_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic [spli_pkg::CNT_W-1:0] frame_count,
    input  logic                       out_free,
    output logic                       s_ready,
    output spli_pkg::ctrl_t            ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WRAP,
        ST_RUN
    } state_t;

    state_t                     state_reg;
    logic [spli_pkg::CNT_W-1:0] count_reg;
    logic [spli_pkg::K_W-1:0]   k_reg;
    logic [spli_pkg::CNT_W-1:0] count_sat;
    logic                       take;
    logic                       is_last;

    always_comb begin
        if (frame_count > spli_pkg::CNT_W'(spli_pkg::MAX_FRAMES)) begin
            count_sat = spli_pkg::CNT_W'(spli_pkg::MAX_FRAMES);
        end else begin
            count_sat = frame_count;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;
    assign is_last = ({1'b0, k_reg} + spli_pkg::CNT_W'(1)) == count_reg;

    assign ctrl.capture   = take;
    assign ctrl.setup     = (state_reg == ST_SETUP);
    assign ctrl.wrap_prep = (state_reg == ST_WRAP);
    assign ctrl.advance   = (state_reg == ST_RUN) && out_free;
    assign ctrl.last      = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    // A request for zero frames produces nothing.
                    if (take && count_sat != '0) begin
                        count_reg <= count_sat;
                        k_reg     <= '0;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    state_reg <= ST_WRAP;
                end
                ST_WRAP: begin
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (out_free) begin
                        k_reg <= k_reg + spli_pkg::K_W'(1);
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/spli_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spli_dp
// Position accumulator and record formation: one adder steps the position
// each advance cycle, with the loop wrap folded into a precomputed step.
// ----------------------------------------------------------------------------
module spli_dp (
    input  logic                        aclk,
    input  spli_pkg::ctrl_t             ctrl,
    input  logic [spli_pkg::POS_W-1:0]  start_position,
    input  logic [spli_pkg::INC_W-1:0]  increment,
    input  logic [spli_pkg::MF_W-1:0]   max_frame,
    input  logic                        honor_loop_points,
    input  logic                        audio_present,
    input  logic [spli_pkg::IDX_W-1:0]  total_frames,
    input  logic                        loop_present,
    input  logic [spli_pkg::IDX_W-1:0]  loop_start,
    input  logic [spli_pkg::IDX_W-1:0]  loop_last,
    output spli_pkg::rec_t              rec
);

    localparam int FW = spli_pkg::FRAC_W;
    localparam int AW = spli_pkg::ACC_W;
    localparam int IW = spli_pkg::IDX_W;

    logic [AW-1:0]                   pos_reg;
    logic [spli_pkg::REL_W-1:0]      rel_reg;
    logic [spli_pkg::INC_W-1:0]      inc_reg;
    logic [spli_pkg::MF_W-1:0]       mf_reg;
    logic                            honor_reg;
    logic [IW-1:0]                   limit_reg;
    logic                            looping_reg;
    logic signed [AW:0]              thresh_reg;
    logic signed [spli_pkg::DELTA_W-1:0] delta_reg;
    logic signed [AW:0]              step_wrap_reg;

    logic [IW-1:0]                   limit_next;
    logic                            tail;
    logic                            looping_next;
    logic [IW+FW:0]                  end_fix;
    logic signed [AW:0]              step;
    logic signed [AW:0]              sum;
    logic [AW-1:0]                   pos_next;
    logic                            wrap;
    logic                            in_range;
    logic [IW-1:0]                   ia;
    logic [IW:0]                     ib_raw;
    logic                            clamp;
    logic [FW-1:0]                   frac;

    // Per-request setup values.
    always_comb begin
        if (mf_reg[spli_pkg::MF_W-1] || mf_reg[IW-1:0] > total_frames) begin
            limit_next = total_frames;
        end else begin
            limit_next = mf_reg[IW-1:0];
        end
        tail         = (total_frames == '0) || (loop_last != total_frames - IW'(1));
        looping_next = loop_present && (!tail || honor_reg);
        end_fix      = {({1'b0, loop_last} + (IW+1)'(1)), {FW{1'b0}}};
    end

    // Position step; the wrap compare is made against end minus increment.
    assign wrap     = looping_reg && ($signed({1'b0, pos_reg}) >= thresh_reg);
    assign step     = wrap ? step_wrap_reg : $signed({{(AW+1-spli_pkg::INC_W){1'b0}}, inc_reg});
    assign sum      = $signed({1'b0, pos_reg}) + step;
    assign pos_next = sum[AW-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            pos_reg   <= {{(AW-spli_pkg::POS_W){1'b0}}, start_position};
            rel_reg   <= {{(spli_pkg::REL_W-FW){1'b0}}, start_position[FW-1:0]};
            inc_reg   <= increment;
            mf_reg    <= max_frame;
            honor_reg <= honor_loop_points;
        end
        if (ctrl.setup) begin
            limit_reg   <= limit_next;
            looping_reg <= looping_next;
            thresh_reg  <= $signed({{(AW-IW-FW){1'b0}}, end_fix})
                         - $signed({{(AW+1-spli_pkg::INC_W){1'b0}}, inc_reg});
            delta_reg   <= $signed({2'b00, loop_start}) - $signed({2'b00, loop_last})
                         - spli_pkg::DELTA_W'(1);
        end
        if (ctrl.wrap_prep) begin
            step_wrap_reg <= $signed({{(AW+1-spli_pkg::INC_W){1'b0}}, inc_reg})
                           + $signed({{(AW+1-spli_pkg::DELTA_W-FW){delta_reg[spli_pkg::DELTA_W-1]}},
                                      delta_reg, {FW{1'b0}}});
        end
        if (ctrl.advance) begin
            pos_reg <= pos_next;
            rel_reg <= rel_reg + {{(spli_pkg::REL_W-spli_pkg::INC_W){1'b0}}, inc_reg};
        end
    end

    // Record for the current position.
    always_comb begin
        in_range = pos_reg[AW-1:FW] < {{(AW-FW-IW){1'b0}}, limit_reg};
        ia       = pos_reg[FW+IW-1:FW];
        frac     = pos_reg[FW-1:0];
        if (looping_reg && ia == loop_last) begin
            ib_raw = {1'b0, loop_start};
        end else begin
            ib_raw = {1'b0, ia} + (IW+1)'(1);
        end
        clamp = ib_raw >= {1'b0, limit_reg};

        rec = '0;
        if (audio_present) begin
            if (in_range) begin
                rec.index_a  = ia;
                rec.index_b  = clamp ? ia : ib_raw[IW-1:0];
                rec.weight_a = (spli_pkg::WA_W)'(1 << FW) - {1'b0, frac};
                rec.weight_b = clamp ? '0 : frac;
            end
            rec.relative_a = rel_reg[FW+spli_pkg::RELA_W-1:FW];
            rec.relative_b = {1'b0, rel_reg[FW+spli_pkg::RELA_W-1:FW]}
                           + spli_pkg::RELB_W'(1);
            if (ctrl.last) begin
                if (|pos_next[AW-1:spli_pkg::POS_W]) begin
                    rec.next_position = '1;
                end else begin
                    rec.next_position = pos_next[spli_pkg::POS_W-1:0];
                end
            end
        end
    end

endmodule

// ===== design/sample_playback_lerp_indexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_playback_lerp_indexer
// Linear interpolation index generator for sample playback with loop points.
// The first record is loaded into the output register after the two setup
// steps (setup, wrap preparation), together with the first position step.
// A request of N frames (1 to 64) is taken only once the last one is done;
// the position accumulator steps once per record, stalled by m_axis_tready.
// Reset (aresetn low, synchronous) clears all configuration to 0 and empties
// the output register; a zero-frame request is consumed with no output.
// ----------------------------------------------------------------------------
module sample_playback_lerp_indexer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spli_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spli_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Low bit up: start_position[39:0], increment[63:40], frame_count[70:64],
    // max_frame[95:71], honor_loop_points[96], zero pad[103:97].
    input  logic [spli_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Low bit up: index_a[23:0], index_b[47:24], weight_a[64:48],
    // weight_b[80:65], relative_a[94:81], relative_b[109:95],
    // next_position[149:110], zero pad[151:150].
    output logic [spli_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int REC_W = $bits(spli_pkg::rec_t);

    logic                           audio_present_reg;
    logic [spli_pkg::IDX_W-1:0]     total_frames_reg;
    logic                           loop_present_reg;
    logic [spli_pkg::IDX_W-1:0]     loop_start_reg;
    logic [spli_pkg::IDX_W-1:0]     loop_last_reg;

    spli_pkg::ctrl_t                ctrl;
    spli_pkg::rec_t                 rec;
    spli_pkg::rec_t                 rec_reg;
    logic                           m_valid_reg;
    logic                           m_last_reg;
    logic                           out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_present_reg <= 1'b0;
            total_frames_reg  <= '0;
            loop_present_reg  <= 1'b0;
            loop_start_reg    <= '0;
            loop_last_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                spli_pkg::CFG_AUDIO_PRESENT: audio_present_reg <= cfg_data[0];
                spli_pkg::CFG_TOTAL_FRAMES:  total_frames_reg  <= cfg_data;
                spli_pkg::CFG_LOOP_PRESENT:  loop_present_reg  <= cfg_data[0];
                spli_pkg::CFG_LOOP_START:    loop_start_reg    <= cfg_data;
                spli_pkg::CFG_LOOP_LAST:     loop_last_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    spli_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_axis_tvalid),
        .frame_count (s_axis_tdata[70:64]),
        .out_free    (out_free),
        .s_ready     (s_axis_tready),
        .ctrl        (ctrl)
    );

    spli_dp u_dp (
        .aclk              (aclk),
        .ctrl              (ctrl),
        .start_position    (s_axis_tdata[39:0]),
        .increment         (s_axis_tdata[63:40]),
        .max_frame         (s_axis_tdata[95:71]),
        .honor_loop_points (s_axis_tdata[96]),
        .audio_present     (audio_present_reg),
        .total_frames      (total_frames_reg),
        .loop_present      (loop_present_reg),
        .loop_start        (loop_start_reg),
        .loop_last         (loop_last_reg),
        .rec               (rec)
    );

    // Output register: a record beat is loaded whenever the sequencer is running and the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else if (ctrl.advance) begin
            m_valid_reg <= 1'b1;
            m_last_reg  <= ctrl.last;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            rec_reg <= rec;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{(spli_pkg::M_DATA_W-REC_W){1'b0}}, rec_reg};

endmodule
